// ===== rtl/sha256_hash_macros.svh =====
// Assertion macros shared by the SHA-256 RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SHA256_HASH_MACROS_SVH
`define SHA256_HASH_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SHA256_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SHA256_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
// Constants, types and round functions for the SHA-256 core.
// No dependencies; used by sha256_round and sha256_hash.
package sha256_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned RND_W = 6;
	localparam int unsigned SEL_W = 3;

	localparam word_t PAD_WORD = 32'h8000_0000;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Control from the sequencer to the round unit.
	typedef struct packed {
		logic              load;      // shift load_word into the schedule window
		word_t             load_word;
		logic              start;     // copy chain into working registers
		logic              round;     // run one round and roll the window
		logic [RND_W-1:0]  rnd;
		logic              fold;      // add working registers into chain
		logic              restore;   // return chain to the initial value
		logic [SEL_W-1:0]  sel;       // chain word shown on the read port
	} rnd_ctl_t;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t bsig0(word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t ssig0(word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/sha256_round.sv =====
// SHA-256 round unit: 16-word schedule window, working registers and chain value.
// Depends on sha256_pkg; driven one step per cycle by sha256_hash.
module sha256_round import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rnd_ctl_t  ctl,
	output word_t     chain_word
);

	word_t win_q [16];
	word_t work_q [8];
	word_t chain_q [8];

	word_t sched_c;
	word_t new_word_c;
	word_t t1_c;
	word_t t2_c;
	word_t ch_c;
	word_t maj_c;

	always_comb begin
		sched_c = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
		new_word_c = ctl.load ? ctl.load_word : sched_c;
		ch_c = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		maj_c = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1_c = work_q[7] + bsig1(work_q[4]) + ch_c + ROUND_K[ctl.rnd] + win_q[0];
		t2_c = bsig0(work_q[0]) + maj_c;
	end

	assign chain_word = chain_q[ctl.sel];

	// Window: oldest word at index 0, which is the schedule word of this round.
	always_ff @(posedge clk) begin
		if (ctl.load || ctl.round) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= new_word_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (ctl.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1_c;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1_c + t2_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else if (ctl.restore) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + work_q[i];
			end
		end
	end

endmodule

// ===== rtl/sha256_hash.sv =====
// SHA-256 hasher top level: input sequencer, padding, length count, digest output.
// Depends on sha256_pkg, sha256_round and sha256_hash_macros.svh.
//
// Usage: feed the message on the s_ channel as big-endian 32-bit words, first
// byte in bits 31..24. Mark the final word with s_tlast and give its count of
// valid leading bytes (0 to 4, larger values count as 4) in s_tdata[34:32].
// After the final word the block pads the message, appends the bit length and
// sends eight digest beats on the m_ channel, word 0 first, m_tlast on word 7.
// Timing: a word that does not complete a block leaves s_tready high. The word
// that completes a block is followed by a busy phase (64 rounds on the shared
// round unit, one chaining add). After the final word, padding words enter at
// one per cycle, each padded block then takes a start step, 64 rounds and one
// chaining add, and then the digest leaves at one beat per cycle while the m_
// channel does not stall.
// s_tready is high only while the sequencer waits for input. A stalled m_
// channel holds the current beat and pauses the digest sequence; the next
// message may be taken while the last digest beat still waits.
// Reset restores the initial chaining value and clears length and fill.
`include "sha256_hash_macros.svh"

module sha256_hash import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast    // last_word
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PAD  = 5'b00010,
		ST_COMP = 5'b00100,
		ST_FOLD = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [4:0]       cnt_q;
	logic [RND_W-1:0] rnd_q;
	logic [SEL_W-1:0] idx_q;
	logic [63:0]      len_q;
	logic             pend_q;
	logic             len_ok_q;
	logic             final_q;
	logic             pad_q;
	logic             m_tvalid_q;
	word_t            m_word_q;
	logic [SEL_W-1:0] m_idx_q;
	logic             m_last_q;

	rnd_ctl_t   ctl;
	word_t      chain_word;
	word_t      in_data;
	logic [2:0] vb_c;
	word_t      tail_word_c;
	word_t      pad_word_c;
	logic       s_acc;
	logic       out_load;

	assign in_data = s_tdata[31:0];
	assign vb_c    = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// Final word: drop bytes past the valid count and, with fewer than four valid bytes, place the marker byte.
	always_comb begin
		case (vb_c)
			3'd0:    tail_word_c = PAD_WORD;
			3'd1:    tail_word_c = {in_data[31:24], 24'h80_0000};
			3'd2:    tail_word_c = {in_data[31:16], 16'h8000};
			3'd3:    tail_word_c = {in_data[31:8], 8'h80};
			default: tail_word_c = in_data;
		endcase
	end

	always_comb begin
		if (pend_q) begin
			pad_word_c = PAD_WORD;
		end else if (len_ok_q && cnt_q == 5'd14) begin
			pad_word_c = len_q[63:32];
		end else if (len_ok_q && cnt_q == 5'd15) begin
			pad_word_c = len_q[31:0];
		end else begin
			pad_word_c = '0;
		end
	end

	always_comb begin
		ctl = '0;
		ctl.rnd = rnd_q;
		ctl.sel = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				ctl.load      = s_acc;
				ctl.load_word = s_tlast ? tail_word_c : in_data;
				ctl.start     = s_acc && !s_tlast && cnt_q == 5'd15;
			end
			ST_PAD: begin
				ctl.start     = (cnt_q == 5'd16);
				ctl.load      = (cnt_q != 5'd16);
				ctl.load_word = pad_word_c;
			end
			ST_COMP: ctl.round = 1'b1;
			ST_FOLD: ctl.fold = 1'b1;
			ST_OUT:  ctl.restore = out_load && idx_q == 3'd7;
			default: ctl = '0;
		endcase
	end

	sha256_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.chain_word (chain_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rnd_q    <= '0;
			idx_q    <= '0;
			len_q    <= '0;
			pend_q   <= 1'b0;
			len_ok_q <= 1'b0;
			final_q  <= 1'b0;
			pad_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						cnt_q <= 5'(cnt_q + 5'd1);
						if (s_tlast) begin
							len_q    <= len_q + 64'({vb_c, 3'b000});
							pend_q   <= (vb_c == 3'd4);
							len_ok_q <= (cnt_q <= 5'd13);
							final_q  <= 1'b0;
							pad_q    <= 1'b1;
							state_q  <= ST_PAD;
						end else begin
							len_q <= len_q + 64'd32;
							if (cnt_q == 5'd15) begin
								rnd_q   <= '0;
								state_q <= ST_COMP;
							end
						end
					end
				end
				ST_PAD: begin
					if (cnt_q == 5'd16) begin
						rnd_q   <= '0;
						state_q <= ST_COMP;
					end else begin
						cnt_q <= 5'(cnt_q + 5'd1);
						if (pend_q) begin
							pend_q   <= 1'b0;
							len_ok_q <= (cnt_q <= 5'd13);
						end else if (len_ok_q && cnt_q == 5'd15) begin
							final_q <= 1'b1;
						end
					end
				end
				ST_COMP: begin
					rnd_q <= RND_W'(rnd_q + 1'b1);
					if (rnd_q == '1) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					cnt_q <= '0;
					if (final_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (pad_q) begin
						// extra block: a pending marker word, if any, then zeros and the length
						len_ok_q <= 1'b1;
						state_q  <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						idx_q <= SEL_W'(idx_q + 1'b1);
						if (idx_q == 3'd7) begin
							len_q   <= '0;
							cnt_q   <= '0;
							pad_q   <= 1'b0;
							final_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: hold the beat until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_word_q <= chain_word;
			m_idx_q  <= idx_q;
			m_last_q <= (idx_q == 3'd7);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, m_idx_q, m_word_q};
	assign m_tlast  = m_last_q;

	`SHA256_CHECK(a_fill_bound, (state_q != ST_IDLE) || (cnt_q < 5'd16), "fill count overran while idle")
	`SHA256_NEXT(a_round_step, (state_q == ST_COMP) && (rnd_q != 6'd63), (state_q == ST_COMP) && (rnd_q == $past(rnd_q) + 6'd1), "round counter skipped")
	`SHA256_NEXT(a_msg_reset, out_load && (idx_q == 3'd7), (state_q == ST_IDLE) && (len_q == 64'd0) && (cnt_q == 5'd0), "message state not cleared after digest")

endmodule

// ===== tb/sv/sha256_digest_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for sha256_hash: follows message beats into its own SHA-256
// predictor and checks each digest beat in order. Depends on sha256_pkg.
module sha256_digest_checker import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	output int          mismatches,
	output int          digests_due
);

	typedef struct packed {
		word_t      digest;
		logic [2:0] index;
		logic       closing;
	} digest_beat_t;

	word_t        chain [8];
	word_t        blk [16];
	int unsigned  fill;
	logic [63:0]  bit_len;
	digest_beat_t digest_q [$];

	function automatic word_t ror(word_t x, int unsigned n);
		logic [63:0] both;
		both = {x, x} >> n;
		return both[31:0];
	endfunction

	function automatic void compress_blk();
		word_t w [64];
		word_t v [8];
		word_t t1, t2, e, a;
		for (int i = 0; i < 16; i++)
			w[i] = blk[i];
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			e  = v[4];
			a  = v[0];
			t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
				+ ROUND_K[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	function automatic void restart_message();
		for (int i = 0; i < 8; i++)
			chain[i] = INIT_H[i];
		fill    = 0;
		bit_len = '0;
	endfunction

	// Fold one message beat into the running hash; a closing beat pads and
	// queues the eight digest words.
	function automatic void absorb_word(word_t data, logic [2:0] vbytes, logic closing);
		int unsigned  nb;
		word_t        keep;
		digest_beat_t beat;
		if (!closing) begin
			blk[fill] = data;
			bit_len   = bit_len + 64'd32;
			fill++;
			if (fill == 16) begin
				compress_blk();
				fill = 0;
			end
			return;
		end
		nb      = (vbytes > 3'd4) ? 4 : vbytes;
		bit_len = bit_len + 64'(8 * nb);
		keep    = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
		blk[fill] = (data & keep) | ((nb < 4) ? (PAD_WORD >> (8 * nb)) : 32'h0);
		fill++;
		// A full last word pushes the pad byte into the following word.
		if (nb == 4) begin
			if (fill == 16) begin
				compress_blk();
				fill = 0;
			end
			blk[fill] = PAD_WORD;
			fill++;
		end
		// No room left for the length: spend an extra block.
		if (fill > 14) begin
			while (fill < 16)
				blk[fill++] = 32'h0;
			compress_blk();
			fill = 0;
		end
		while (fill < 14)
			blk[fill++] = 32'h0;
		blk[14] = bit_len[63:32];
		blk[15] = bit_len[31:0];
		compress_blk();
		for (int i = 0; i < 8; i++) begin
			beat.digest  = chain[i];
			beat.index   = 3'(i);
			beat.closing = (i == 7);
			digest_q.push_back(beat);
		end
		restart_message();
	endfunction

	always @(posedge clk) begin
		digest_beat_t want;
		if (!arst_n) begin
			restart_message();
			for (int i = 0; i < 16; i++)
				blk[i] = 32'h0;
			digest_q.delete();
			mismatches = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					$error("digest beat %h with no digest pending", m_tdata);
					mismatches++;
				end else begin
					want = digest_q.pop_front();
					if (m_tdata[31:0] !== want.digest) begin
						$error("digest_word: expected %h, got %h", want.digest, m_tdata[31:0]);
						mismatches++;
					end
					if (m_tdata[34:32] !== want.index) begin
						$error("word_index: expected %0d, got %0d", want.index, m_tdata[34:32]);
						mismatches++;
					end
					if (m_tlast !== want.closing) begin
						$error("last_word: expected %b, got %b", want.closing, m_tlast);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				absorb_word(s_tdata[31:0], s_tdata[34:32], s_tlast);
		end
		digests_due = digest_q.size();
	end

endmodule

// ===== tb/sv/sha256_hash_tb.sv =====
`timescale 1ns / 1ps
// Top of the sha256_hash testbench: clock, reset, message stimulus and verdict.
// Depends on sha256_pkg, sha256_hash and sha256_digest_checker.
module sha256_hash_tb;
	import sha256_pkg::*;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	int mismatches;
	int digests_due;
	int words_sent  = 0;
	bit tx_gaps     = 1'b1;
	bit rx_hold_req = 1'b0;

	always #5 clk = ~clk;

	sha256_hash DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sha256_digest_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.digests_due (digests_due)
	);

	function automatic word_t pick_word(fill_t kind);
		case (kind)
			FILL_ZERO: return 32'h0;
			FILL_ONES: return 32'hffff_ffff;
			default:   return $urandom;
		endcase
	endfunction

	// Offer one beat from the falling edge on; hold it until the handshake.
	task automatic send_word(word_t data, logic [2:0] vbytes, logic closing);
		while (tx_gaps && $urandom_range(99) < 18) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, vbytes, data};
		s_tlast  <= closing;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	// Body beats carry a random byte count, which the block must ignore.
	task automatic send_message(int body_words, logic [2:0] tail_bytes, fill_t kind);
		for (int i = 0; i < body_words; i++)
			send_word(pick_word(kind), 3'($urandom_range(7)), 1'b0);
		send_word(pick_word(kind), tail_bytes, 1'b1);
	endtask

	task automatic wait_for_digests();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (digests_due != 0)
			@(negedge clk);
	endtask

	initial begin
		int    body;
		int    roll;
		fill_t kind;
		bit    paused;
		paused = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_message(0, 3'd0, FILL_ONES);     // empty message
		send_message(0, 3'd1, FILL_ONES);     // trailing bytes must be dropped
		send_message(0, 3'd2, FILL_ZERO);
		send_message(0, 3'd3, FILL_RANDOM);
		send_message(0, 3'd4, FILL_ONES);     // pad byte in the next word
		send_message(0, 3'd5, FILL_RANDOM);   // oversized counts act as four
		send_message(0, 3'd7, FILL_ONES);
		send_message(1, 3'd6, FILL_ZERO);
		send_message(2, 3'd0, FILL_RANDOM);   // message ends on a word boundary
		send_message(3, 3'd4, FILL_ZERO);
		wait_for_digests();

		rx_hold_req = 1'b1;
		while (words_sent < 300) begin
			roll = $urandom_range(99);
			// Favor lengths where padding spills into an extra block.
			if (roll < 40)
				body = $urandom_range(12);
			else if (roll < 75)
				body = $urandom_range(16, 13);
			else if (roll < 90)
				body = $urandom_range(32, 28);
			else
				body = $urandom_range(47, 17);
			roll = $urandom_range(99);
			kind = (roll < 4) ? FILL_ZERO : (roll < 8) ? FILL_ONES : FILL_RANDOM;
			tx_gaps = !(words_sent >= 200 && words_sent < 260);
			send_message(body, 3'($urandom_range(7)), kind);
			if (!paused && words_sent >= 150) begin
				paused = 1'b1;
				wait_for_digests();
			end
		end
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (digests_due != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0 && digests_due == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Digest sink: random backpressure, one long hold while messages keep
	// coming, and a stretch that accepts every beat.
	initial begin
		int cyc;
		cyc = 0;
		while (!rx_hold_req) begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= 18);
		end
		@(negedge clk);
		m_tready <= 1'b0;
		repeat (400) @(negedge clk);
		forever begin
			cyc++;
			if (cyc >= 300 && cyc < 1300)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 18);
			@(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sha256_hash.f =====
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_round.sv
rtl/sha256_hash.sv
tb/sv/sha256_digest_checker.sv
tb/sv/sha256_hash_tb.sv
